### sv/sos_pkg.sv
// shared types and constants for the stereo output stage
`timescale 1ns / 1ps

package sos_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SM_LVL,
		ST_SM_CEIL,
		ST_DC_L,
		ST_DC_R,
		ST_GAIN_L,
		ST_GAIN_R,
		ST_GAIN_WAIT,
		ST_SIDE,
		ST_MIX,
		ST_DONE
	} seq_state_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CEIL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DC_EN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POLE   = 3'd4;

	typedef struct packed {
		logic [15:0] level_target;
		logic [15:0] spread_amount;
		logic [22:0] clip_ceiling;
		logic        dc_filter_enable;
		logic [23:0] dc_pole;
	} cfg_t;

	localparam logic [15:0] LEVEL_RESET  = 16'd16384;
	localparam logic [15:0] SPREAD_RESET = 16'd16384;
	localparam logic [22:0] CEIL_RESET   = 23'd8388607;
	localparam logic [23:0] POLE_RESET   = 24'd16760439;
	localparam logic [15:0] LEVEL_MAX    = 16'd32768;

	// smoother state: level in Q2.30, ceiling in Q1.31
	localparam logic [31:0] LEVEL_SM_RESET = 32'h4000_0000;
	localparam logic [31:0] CEIL_SM_RESET  = 32'h7FFF_FF00;

	// second multiplier operand, signed
	localparam int MUL_B_W = 25;
	// 0.001 in Q0.24
	localparam logic signed [MUL_B_W-1:0] SMOOTH_COEF = 25'sd16777;

endpackage

### sv/sos_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module sos_mul
	import sos_pkg::*;
#(
	parameter int A_W = 33
) (
	input  logic                           clk,
	input  logic signed [A_W-1:0]          a,
	input  logic signed [MUL_B_W-1:0]      b,
	output logic signed [A_W+MUL_B_W-1:0]  p
);

	logic signed [A_W+MUL_B_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

### sv/sos_seq.sv
// sequencer and datapath registers around the shared multiplier
`timescale 1ns / 1ps

module sos_seq
	import sos_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int A_W = 35
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cfg_t                            cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [SAMPLE_BITS-1:0]   in_left,
	input  logic signed [SAMPLE_BITS-1:0]   in_right,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic signed [SAMPLE_BITS-1:0]   res_left,
	output logic signed [SAMPLE_BITS-1:0]   res_right,
	output logic signed [A_W-1:0]           mul_a,
	output logic signed [MUL_B_W-1:0]       mul_b,
	input  logic signed [A_W+MUL_B_W-1:0]   mul_p
);

	localparam int SB  = SAMPLE_BITS;
	localparam int PW  = A_W + MUL_B_W;
	localparam int SHL = (SB >= 24) ? SB - 24 : 0;
	localparam int SHR = (SB < 24) ? 24 - SB : 0;
	localparam logic [32:0] SMAX33 = 33'((64'd1 << (SB - 1)) - 64'd1);
	localparam logic signed [PW-1:0] HALF24 = PW'(1) <<< 23;
	localparam logic signed [PW-1:0] HALF14 = PW'(1) <<< 14;
	localparam logic signed [PW-1:0] HALF13 = PW'(1) <<< 13;
	localparam logic signed [PW-1:0] SMAX_P = PW'(SMAX33);
	localparam logic signed [PW-1:0] SMIN_P = -SMAX_P - PW'(1);

	seq_state_t state_q, state_d;

	// model state
	logic [31:0]             level_q, ceil_sm_q;
	logic signed [SB-1:0]    pil_q, pfl_q, pir_q, pfr_q;
	// per item payload
	logic signed [SB-1:0]    l_in_q, r_in_q, yl_q, yr_q, res_l_q, res_r_q;
	logic signed [SB+1:0]    gl_q, gr_q;
	logic [15:0]             lvl_q;
	logic [SB-1:0]           ceil_q;

	logic [15:0]             lt;
	logic signed [32:0]      d_lvl, d_ceil;
	logic signed [PW-1:0]    r24, gain_w, y_raw, y_sat_w, num_m, mix_l, mix_r, ceil_p;
	logic signed [SB-1:0]    dc_x, dc_pi, y_sat;
	logic [32:0]             lvl_w, c_w, ce;
	logic [23:0]             c23;
	logic [SB-1:0]           ceil_next;
	logic signed [SB+2:0]    dif;

	always_comb begin
		lt     = (cfg.level_target > LEVEL_MAX) ? LEVEL_MAX : cfg.level_target;
		d_lvl  = $signed({1'b0, lt, 16'b0}) - $signed({1'b0, level_q});
		d_ceil = $signed({2'b0, cfg.clip_ceiling, 8'b0}) - $signed({1'b0, ceil_sm_q});
		r24    = (mul_p + HALF24) >>> 24;
		gain_w = (mul_p + HALF13) >>> 14;

		// dc blocker: left result is taken in ST_DC_R, right in ST_GAIN_L
		dc_x    = (state_q == ST_DC_R) ? l_in_q : r_in_q;
		dc_pi   = (state_q == ST_DC_R) ? pil_q : pir_q;
		y_raw   = PW'(dc_x) - PW'(dc_pi) + r24;
		y_sat_w = (y_raw > SMAX_P) ? SMAX_P : ((y_raw < SMIN_P) ? SMIN_P : y_raw);
		y_sat   = y_sat_w[SB-1:0];

		lvl_w = {1'b0, level_q} + 33'd32768;
		c_w   = {1'b0, ceil_sm_q} + 33'd128;
		c23   = c_w[31:8];
		ce    = (33'(c23) << SHL) >> SHR;
		ceil_next = (ce > SMAX33) ? SMAX33[SB-1:0] : ce[SB-1:0];

		dif    = (SB+3)'(gl_q) - (SB+3)'(gr_q);
		num_m  = (PW'(gl_q) + PW'(gr_q)) <<< 14;
		mix_l  = (num_m + mul_p + HALF14) >>> 15;
		mix_r  = (num_m - mul_p + HALF14) >>> 15;
		ceil_p = $signed(PW'(ceil_q));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_SM_LVL;
			ST_SM_LVL:    state_d = ST_SM_CEIL;
			ST_SM_CEIL:   state_d = ST_DC_L;
			ST_DC_L:      state_d = ST_DC_R;
			ST_DC_R:      state_d = ST_GAIN_L;
			ST_GAIN_L:    state_d = ST_GAIN_R;
			ST_GAIN_R:    state_d = ST_GAIN_WAIT;
			ST_GAIN_WAIT: state_d = ST_SIDE;
			ST_SIDE:      state_d = ST_MIX;
			ST_MIX:       state_d = ST_DONE;
			ST_DONE:      if (res_ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SM_LVL: begin
				mul_a = A_W'(d_lvl);
				mul_b = SMOOTH_COEF;
			end
			ST_SM_CEIL: begin
				mul_a = A_W'(d_ceil);
				mul_b = SMOOTH_COEF;
			end
			ST_DC_L: begin
				mul_a = A_W'(pfl_q);
				mul_b = $signed({1'b0, cfg.dc_pole});
			end
			ST_DC_R: begin
				mul_a = A_W'(pfr_q);
				mul_b = $signed({1'b0, cfg.dc_pole});
			end
			ST_GAIN_L: begin
				mul_a = A_W'(cfg.dc_filter_enable ? yl_q : l_in_q);
				mul_b = $signed({9'b0, lvl_q});
			end
			ST_GAIN_R: begin
				mul_a = A_W'(cfg.dc_filter_enable ? yr_q : r_in_q);
				mul_b = $signed({9'b0, lvl_q});
			end
			ST_SIDE: begin
				mul_a = A_W'(dif);
				mul_b = $signed({9'b0, cfg.spread_amount});
			end
			ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			level_q   <= LEVEL_SM_RESET;
			ceil_sm_q <= CEIL_SM_RESET;
			pil_q     <= '0;
			pfl_q     <= '0;
			pir_q     <= '0;
			pfr_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SM_CEIL) level_q <= level_q + r24[31:0];
			if (state_q == ST_DC_L) ceil_sm_q <= ceil_sm_q + r24[31:0];
			// filter history only moves while the filter is on
			if (state_q == ST_GAIN_L && cfg.dc_filter_enable) begin
				pil_q <= l_in_q;
				pfl_q <= yl_q;
				pir_q <= r_in_q;
				pfr_q <= y_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					l_in_q <= in_left;
					r_in_q <= in_right;
				end
			end
			ST_DC_L:      lvl_q <= lvl_w[31:16];
			ST_DC_R: begin
				yl_q   <= y_sat;
				ceil_q <= ceil_next;
			end
			ST_GAIN_L:    yr_q <= y_sat;
			ST_GAIN_R:    gl_q <= gain_w[SB+1:0];
			ST_GAIN_WAIT: gr_q <= gain_w[SB+1:0];
			ST_MIX: begin
				res_l_q <= (mix_l > ceil_p) ? ceil_p[SB-1:0] :
					((mix_l < -ceil_p) ? SB'(-ceil_p) : mix_l[SB-1:0]);
				res_r_q <= (mix_r > ceil_p) ? ceil_p[SB-1:0] :
					((mix_r < -ceil_p) ? SB'(-ceil_p) : mix_r[SB-1:0]);
			end
			default: ;
		endcase
	end

	assign res_left  = res_l_q;
	assign res_right = res_r_q;

endmodule

### sv/stereo_output_stage.sv
// stereo output stage top level: config registers, sequencer, output register
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: left_sample, right_sample
//  m_*     | out | m_tvalid/m_tready  | m_tdata: left_out, right_out
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// each sample pair runs seven products through the one multiplier,
// then mix/clip and hand-off to the output register
// s_tready is high only while the sequencer is idle; a full output register
// that is not drained holds the sequencer before it returns to idle
// reset clears the smoothers to unity gain and full scale, dc history to zero
// cfg_ready is always high
`timescale 1ns / 1ps

module stereo_output_stage
	import sos_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// left_sample, right_sample, zero pad
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// left_out, right_out, zero pad
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]                     cfg_index,
	input  logic [CFG_DATA_W-1:0]                    cfg_data
);

	localparam int SB  = SAMPLE_BITS;
	localparam int DW  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int A_W = (SAMPLE_BITS + 3 > 33) ? SAMPLE_BITS + 3 : 33;

	cfg_t cfg_q;
	logic                             m_tvalid_q;
	logic [DW-1:0]                    m_tdata_q;
	logic                             res_valid, res_ready;
	logic signed [SB-1:0]             res_left, res_right;
	logic signed [A_W-1:0]            mul_a;
	logic signed [MUL_B_W-1:0]        mul_b;
	logic signed [A_W+MUL_B_W-1:0]    mul_p;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_target     <= LEVEL_RESET;
			cfg_q.spread_amount    <= SPREAD_RESET;
			cfg_q.clip_ceiling     <= CEIL_RESET;
			cfg_q.dc_filter_enable <= 1'b0;
			cfg_q.dc_pole          <= POLE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LEVEL:  cfg_q.level_target     <= cfg_data[15:0];
				CFG_SPREAD: cfg_q.spread_amount    <= cfg_data[15:0];
				CFG_CEIL:   cfg_q.clip_ceiling     <= cfg_data[22:0];
				CFG_DC_EN:  cfg_q.dc_filter_enable <= cfg_data[0];
				CFG_POLE:   cfg_q.dc_pole          <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	sos_mul #(
		.A_W(A_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	sos_seq #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.A_W        (A_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_left   ($signed(s_tdata[SB-1:0])),
		.in_right  ($signed(s_tdata[2*SB-1:SB])),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_left  (res_left),
		.res_right (res_right),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_p     (mul_p)
	);

	// output register frees the sequencer from the downstream stall
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= DW'({res_right, res_left});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### sv/sos_chk.sv
// port-level checks for the stereo output stage
`timescale 1ns / 1ps

module sos_chk #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed under stall");

	// one pair at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a request");

	// a new result only appears from the busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while idle");

	// no result in the cycle after a request
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too soon after request");

endmodule

bind stereo_output_stage sos_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_sos_chk (.*);

### verif/sos_pair_checker.sv
// scoreboard for the stereo output stage: predicts each processed pair and checks the outputs
`timescale 1ns / 1ps

module sos_pair_checker
	import sos_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// left_sample, right_sample
	input  logic [47:0]           s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// left_out, right_out
	input  logic [47:0]           m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);

	localparam longint S_MAX = 64'sd8388607;
	localparam longint S_MIN = -S_MAX - 1;
	// 0.001 in Q0.24
	localparam longint SMOOTH_Q24 = 64'sd16777;
	localparam logic [15:0] LEVEL_CAP = 16'd32768;

	typedef struct packed {
		logic [23:0] right;
		logic [23:0] left;
	} stereo_pair_t;

	cfg_t           regs;
	logic [31:0]    gain_sm;
	logic [31:0]    ceil_sm;
	longint         hist_in_l, hist_out_l, hist_in_r, hist_out_r;
	stereo_pair_t   pending_pairs[$];
	stereo_pair_t   got, want;

	// round half up, also for negative values
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint saturate(longint v);
		if (v > S_MAX) return S_MAX;
		if (v < S_MIN) return S_MIN;
		return v;
	endfunction

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic logic [31:0] glide(logic [31:0] z, longint goal);
		longint delta;
		delta = goal - longint'(z);
		return 32'(longint'(z) + round_shift(delta * SMOOTH_Q24, 24));
	endfunction

	function automatic stereo_pair_t processed_pair(stereo_pair_t x);
		longint gain, ceil_now, l, r, mid, side;
		stereo_pair_t y;
		gain_sm = glide(gain_sm, longint'(regs.level_target > LEVEL_CAP ?
			LEVEL_CAP : regs.level_target) <<< 16);
		ceil_sm = glide(ceil_sm, longint'(regs.clip_ceiling) <<< 8);
		gain = round_shift(longint'(gain_sm), 16);
		ceil_now = round_shift(longint'(ceil_sm), 8);
		if (ceil_now > S_MAX) ceil_now = S_MAX;
		if (ceil_now < 0) ceil_now = 0;
		l = longint'($signed(x.left));
		r = longint'($signed(x.right));
		if (regs.dc_filter_enable) begin
			l = saturate(l - hist_in_l +
				round_shift(longint'(regs.dc_pole) * hist_out_l, 24));
			r = saturate(r - hist_in_r +
				round_shift(longint'(regs.dc_pole) * hist_out_r, 24));
			hist_in_l = longint'($signed(x.left));
			hist_in_r = longint'($signed(x.right));
			hist_out_l = l;
			hist_out_r = r;
		end
		l = round_shift(l * gain, 14);
		r = round_shift(r * gain, 14);
		// mid/side with a single rounding
		mid = (l + r) * 16384;
		side = (l - r) * longint'(regs.spread_amount);
		l = clamp_mag(round_shift(mid + side, 15), ceil_now);
		r = clamp_mag(round_shift(mid - side, 15), ceil_now);
		y.left = l[23:0];
		y.right = r[23:0];
		return y;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatches = 0;
			regs.level_target = 16'd16384;
			regs.spread_amount = 16'd16384;
			regs.clip_ceiling = 23'd8388607;
			regs.dc_filter_enable = 1'b0;
			regs.dc_pole = 24'd16760439;
			gain_sm = 32'd16384 << 16;
			ceil_sm = 32'd8388607 << 8;
			hist_in_l = 0;
			hist_out_l = 0;
			hist_in_r = 0;
			hist_out_r = 0;
			pending_pairs.delete();
		end else begin
			// results leave before this edge's request can be turned around
			if (m_tvalid && m_tready) begin
				got = stereo_pair_t'(m_tdata);
				if (pending_pairs.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected output pair, expected none, got %0d / %0d",
						$time, $signed(got.left), $signed(got.right));
				end else begin
					want = pending_pairs.pop_front();
					if (got.left !== want.left) begin
						mismatches++;
						$display("%0t: left_out expected %0d, got %0d",
							$time, $signed(want.left), $signed(got.left));
					end
					if (got.right !== want.right) begin
						mismatches++;
						$display("%0t: right_out expected %0d, got %0d",
							$time, $signed(want.right), $signed(got.right));
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_pairs.push_back(processed_pair(stereo_pair_t'(s_tdata)));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LEVEL: begin
						regs.level_target = cfg_data[15:0];
					end
					CFG_SPREAD: begin
						regs.spread_amount = cfg_data[15:0];
					end
					CFG_CEIL: begin
						regs.clip_ceiling = cfg_data[22:0];
					end
					CFG_DC_EN: begin
						regs.dc_filter_enable = cfg_data[0];
					end
					CFG_POLE: begin
						regs.dc_pole = cfg_data[23:0];
					end
					default: begin
					end
				endcase
			end
		end
		pending = pending_pairs.size();
	end

endmodule

### verif/tb_stereo_output_stage.sv
// testbench top for the stereo output stage: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_stereo_output_stage;
	import sos_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 166;
	localparam logic [23:0] S_MAX = 24'h7FFFFF;
	localparam logic [23:0] S_MIN = 24'h800000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_POLE + 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

	typedef enum int {
		WAVE_NOISE,
		WAVE_QUIET,
		WAVE_EDGE,
		WAVE_OFFSET
	} sample_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           s_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b1;
	logic [47:0]           m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatch_count;
	int                    pending_results;
	int                    sender_idle = 0;
	int                    receiver_stall = 0;

	stereo_output_stage u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sos_pair_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatch_count),
		.pending    (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= receiver_stall);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	task automatic send_pair(logic [23:0] smp_l, logic [23:0] smp_r);
		while ($urandom_range(0, 99) < sender_idle) begin
			s_tvalid <= 1'b0;
			s_tdata <= {16'($urandom), $urandom};
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {smp_r, smp_l};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes run without a gap
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		logic [CFG_DATA_W-1:0] word;
		// bits above the register width are junk the block must drop
		word = CFG_DATA_W'($urandom);
		case (idx)
			CFG_LEVEL, CFG_SPREAD: begin
				word[15:0] = value[15:0];
			end
			CFG_CEIL: begin
				word[22:0] = value[22:0];
			end
			CFG_DC_EN: begin
				word[0] = value[0];
			end
			CFG_POLE: begin
				word = value[23:0];
			end
			default: begin
			end
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
	endtask

	function automatic logic [23:0] pick_sample(sample_kind_t kind, logic [23:0] bias);
		logic [23:0] v;
		case (kind)
			WAVE_NOISE: begin
				v = 24'($urandom);
			end
			WAVE_QUIET: begin
				v = 24'(int'($urandom_range(0, 512)) - 256);
			end
			WAVE_EDGE: begin
				case ($urandom_range(0, 4))
					0: v = S_MAX;
					1: v = S_MIN;
					2: v = '0;
					3: v = '1;
					default: v = 24'd1;
				endcase
			end
			default: begin
				v = bias + 24'(int'($urandom_range(0, 2048)) - 1024);
			end
		endcase
		return v;
	endfunction

	function automatic int unsigned pick_gain();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16384;
			2: return 32768;
			3: return 65535;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	initial begin : stimulus
		sample_kind_t kind;
		logic [23:0]  smp_l, smp_r, bias;
		int unsigned  roll;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LEVEL;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings, field extremes
		send_pair('0, '0);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MAX, S_MIN);
		send_pair(S_MIN, S_MAX);
		send_pair('1, 24'd1);
		send_pair(24'h555555, 24'hAAAAAA);
		send_pair(24'hAAAAAA, 24'h555555);

		// gain above range, widest side, zero ceiling, dc blocker with pole just below one
		wait_all_results();
		write_reg(CFG_LEVEL, 65535);
		write_reg(CFG_SPREAD, 65535);
		write_reg(CFG_CEIL, 0);
		write_reg(CFG_DC_EN, 1);
		write_reg(CFG_POLE, 24'hFFFFFF);
		write_reg(CFG_UNUSED_LO, $urandom);
		write_reg(CFG_UNUSED_HI, $urandom);
		cfg_valid <= 1'b0;
		send_pair(S_MIN, S_MAX);
		send_pair(S_MAX, S_MIN);
		send_pair(S_MAX, S_MIN);
		send_pair(S_MIN, S_MIN);
		send_pair('0, '0);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MAX, S_MAX);

		// zero gain, no side, pole at zero, full ceiling
		wait_all_results();
		write_reg(CFG_LEVEL, 0);
		write_reg(CFG_SPREAD, 0);
		write_reg(CFG_POLE, 0);
		write_reg(CFG_CEIL, 23'h7FFFFF);
		cfg_valid <= 1'b0;
		send_pair(S_MAX, S_MIN);
		send_pair(24'd1, '1);
		send_pair(S_MIN, S_MAX);

		// filter off again, gain just above the cap
		wait_all_results();
		write_reg(CFG_DC_EN, 0);
		write_reg(CFG_LEVEL, 32769);
		write_reg(CFG_SPREAD, 32768);
		cfg_valid <= 1'b0;
		send_pair(S_MAX, S_MIN);
		send_pair(S_MIN, S_MAX);
		send_pair(S_MAX, S_MAX);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_all_results();
			case (ph % 4)
				0: begin
					sender_idle = 0;
					receiver_stall = 0;
				end
				1: begin
					sender_idle = 52;
					receiver_stall = 0;
				end
				2: begin
					sender_idle = 0;
					receiver_stall = 52;
				end
				default: begin
					sender_idle = 18;
					receiver_stall = 18;
				end
			endcase
			write_reg(CFG_LEVEL, pick_gain());
			write_reg(CFG_SPREAD, pick_gain());
			case ($urandom_range(0, 4))
				0: write_reg(CFG_CEIL, 0);
				1: write_reg(CFG_CEIL, 23'h7FFFFF);
				2: write_reg(CFG_CEIL, $urandom_range(0, 4096));
				default: write_reg(CFG_CEIL, $urandom_range(0, 23'h7FFFFF));
			endcase
			write_reg(CFG_DC_EN, $urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: write_reg(CFG_POLE, 0);
				1: write_reg(CFG_POLE, 24'hFFFFFF);
				2: write_reg(CFG_POLE, $urandom_range(0, 24'hFFFFFF));
				default: write_reg(CFG_POLE, 24'hFFFFFF - $urandom_range(0, 65535));
			endcase
			if ($urandom_range(0, 1) != 0)
				write_reg(CFG_UNUSED_LO + 3'($urandom_range(0, 2)), $urandom);
			cfg_valid <= 1'b0;
			bias = 24'($urandom);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold off mid-phase until the pipeline has emptied
				if (ph == 1 && n == PHASE_ITEMS / 2)
					wait_all_results();
				roll = $urandom_range(0, 99);
				if (roll < 40)
					kind = WAVE_NOISE;
				else if (roll < 55)
					kind = WAVE_QUIET;
				else if (roll < 65)
					kind = WAVE_EDGE;
				else
					kind = WAVE_OFFSET;
				smp_l = pick_sample(kind, bias);
				// some pure mid and pure side pairs
				case ($urandom_range(0, 9))
					0: smp_r = smp_l;
					1: smp_r = -smp_l;
					default: smp_r = pick_sample(kind, bias);
				endcase
				send_pair(smp_l, smp_r);
			end
		end

		wait_all_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
sv/sos_pkg.sv
sv/sos_mul.sv
sv/sos_seq.sv
sv/stereo_output_stage.sv
sv/sos_chk.sv
verif/sos_pair_checker.sv
verif/tb_stereo_output_stage.sv
